// ===== design/rlhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rlhs_pkg: shared types and constants for the RGB to luma/hue/saturation block
// Luma weights in thousandths, the magnitude scale and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rlhs_pkg;

  // Luma weights, scaled by 1000
  localparam int unsigned WR = 299;
  localparam int unsigned WG = 587;
  localparam int unsigned WB = 114;

  // Chroma magnitude is scaled by 1/1000; squared and quartered this is 250000
  localparam int unsigned SQ_SCALE = 250000;

  localparam real PI_VAL = 3.14159265358979323846;

  // Turns per radian
  localparam real TURN_PER_RAD = 1.0 / (2.0 * PI_VAL);

  // Quadrant and special-case flags that ride along with the CORDIC item
  typedef struct packed {
    logic a_neg;   // C1 (the y term) below zero
    logic b_neg;   // C2 (the x term) below zero
    logic gray;    // both chroma differences zero
  } chroma_flags_t;

  // atan(2^-idx) in turns, with aw fraction bits, rounded
  function automatic longint atan_turn(input int idx, input int aw);
    real v;
    v = $atan(2.0 ** (-idx)) * TURN_PER_RAD * (2.0 ** aw);
    return longint'(v);
  endfunction

endpackage

// ===== design/rgb_to_luma_hue_saturation.sv =====
// ----------------------------------------------------------------------------
// rgb_to_luma_hue_saturation: pixel color space converter
// Luma by constant weights, hue by a pipelined CORDIC vectoring unit and
// saturation by a pipelined bit-per-stage square root, all fixed point.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the depth is set by
//   the CORDIC chain of FRAC_BITS + 18 iterations, one iteration per stage.
// Each stage advances when it is empty or the stage after it advances.
// Reset clears the valid bits only; payload registers are not reset.
module rgb_to_luma_hue_saturation
  import rlhs_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] luma,
  output logic [15:0] hue,
  output logic [15:0] saturation
);

  localparam int F  = FRAC_BITS;
  localparam int AW = F + 20;          // angle fraction bits, in turns
  localparam int NI = AW - 2;          // CORDIC iterations
  localparam int XW = 20 + NI;         // CORDIC x/y width with guard bits
  localparam int ZW = AW + 1;          // signed angle accumulator
  localparam int D  = NI + 5;          // pipeline depth
  localparam int RW = 2 * F + 56;      // square root remainder width
  localparam int NS = D - 21;          // saturation delay stages
  localparam int NL = D - 6;           // luma delay stages

  // Division of luma by 1000 as /8 then two reciprocal steps by 125
  localparam int     K1  = 25;
  localparam longint M1  = ((longint'(1) <<< K1) + 124) / 125;
  localparam int     N2  = F + 5;
  localparam int     K2  = N2 + 7;
  localparam int     M2W = K2 - 6;
  localparam longint M2  = ((longint'(1) <<< K2) + 124) / 125;
  localparam int     QW  = F - 2;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(longint'(1) <<< (AW - 2));
  localparam logic signed [ZW-1:0] HALF    = ZW'(longint'(1) <<< (AW - 1));

  // Handshake chain
  logic [D:1]   v;
  logic [D+1:1] en;

  assign en[D+1] = result_ready;
  for (genvar s = 1; s <= D; s++) begin : g_en
    assign en[s] = !v[s] || en[s+1];
  end

  assign pixel_ready  = en[1];
  assign result_valid = v[D];

  // Advance valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= pixel_valid;
      end
      for (int s = 2; s <= D; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  // Stage 1: capture pixel
  logic [7:0] red1, green1, blue1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      red1   <= red;
      green1 <= green;
      blue1  <= blue;
    end
  end

  // Stage 2: weighted sum and chroma differences
  logic [17:0]        ysum2;
  logic signed [19:0] c1_2, c2_2;
  logic signed [19:0] r20, g20, b20;
  assign r20 = $signed(20'(red1));
  assign g20 = $signed(20'(green1));
  assign b20 = $signed(20'(blue1));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ysum2 <= 18'(18'(WR) * 18'(red1)) + 18'(18'(WG) * 18'(green1))
             + 18'(18'(WB) * 18'(blue1));
      c1_2  <= 20'sd701 * r20 - 20'sd587 * g20 - 20'sd114 * b20;
      c2_2  <= 20'sd886 * b20 - 20'sd299 * r20 - 20'sd587 * g20;
    end
  end

  // Stage 3: first reciprocal step, chroma squares, CORDIC load
  logic [17:0]        ysum3;
  logic [10:0]        qa3;
  logic [35:0]        sq1_3, sq2_3;
  logic [36:0]        qa_prod;
  logic signed [39:0] sq1_full, sq2_full;
  logic signed [19:0] ua2, ub2;

  assign qa_prod  = 37'(ysum2) * 37'(M1);
  assign sq1_full = 40'(c1_2) * 40'(c1_2);
  assign sq2_full = 40'(c2_2) * 40'(c2_2);
  assign ua2      = c1_2[19] ? -c1_2 : c1_2;
  assign ub2      = c2_2[19] ? -c2_2 : c2_2;

  logic signed [XW-1:0] cx [0:NI];
  logic signed [XW-1:0] cy [0:NI];
  logic signed [ZW-1:0] cz [0:NI];
  chroma_flags_t        cf [0:NI];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ysum3       <= ysum2;
      qa3         <= qa_prod[K1 +: 11];
      sq1_3       <= sq1_full[35:0];
      sq2_3       <= sq2_full[35:0];
      cx[0]       <= XW'(ub2) <<< NI;
      cy[0]       <= XW'(ua2) <<< NI;
      cz[0]       <= '0;
      cf[0].a_neg <= c1_2[19];
      cf[0].b_neg <= c2_2[19];
      cf[0].gray  <= (c1_2 == '0) && (c2_2 == '0);
    end
  end

  // CORDIC vectoring: one micro-rotation per stage
  for (genvar i = 0; i < NI; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_turn(i, AW));
    always_ff @(posedge clk) begin
      if (en[4+i]) begin
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_I;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_I;
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  // Stage 4: remainder by 125, chroma magnitude squared
  logic [6:0]  ra4;
  logic [10:0] qa4;
  logic [36:0] n4;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ra4 <= 7'(ysum3 - 18'(18'(qa3) * 18'd125));
      qa4 <= qa3;
      n4  <= 37'(sq1_3) + 37'(sq2_3);
    end
  end

  // Stage 5: second reciprocal step, square root load
  logic [10:0]          qa5;
  logic [QW-1:0]        q2_5;
  logic [N2-1:0]        x2;
  logic [N2+M2W-1:0]    q2_prod;
  logic [15:0]          sk [0:16];
  logic signed [RW-1:0] sr [0:16];

  assign x2      = (N2'(ra4) << (F - 3)) + N2'(62);
  assign q2_prod = (N2 + M2W)'(x2) * (N2 + M2W)'(M2);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      qa5   <= qa4;
      q2_5  <= q2_prod[K2 +: QW];
      sk[0] <= '0;
      sr[0] <= $signed(RW'(n4) << (2 * F)) - $signed(RW'(SQ_SCALE));
    end
  end

  // Square root: decide one result bit per stage, most significant first
  for (genvar j = 0; j < 16; j++) begin : g_sqrt
    localparam int B = 15 - j;
    logic [17:0]          t;
    logic [RW-1:0]        cost;
    logic signed [RW-1:0] diff;
    assign t    = {1'b0, sk[j], 1'b0} + 18'(longint'(1) <<< B) - 18'd1;
    assign cost = (RW'(t) * RW'(SQ_SCALE)) << (B + 2);
    assign diff = sr[j] - $signed(cost);
    always_ff @(posedge clk) begin
      if (en[6+j]) begin
        if (!diff[RW-1]) begin
          sk[j+1] <= sk[j] | 16'(longint'(1) <<< B);
          sr[j+1] <= diff;
        end else begin
          sk[j+1] <= sk[j];
          sr[j+1] <= sr[j];
        end
      end
    end
  end

  // Delay saturation to the output stage
  logic [15:0] sat [1:NS];
  for (genvar j = 1; j <= NS; j++) begin : g_sat
    if (j == 1) begin : g_head
      always_ff @(posedge clk) begin
        if (en[21+j]) begin
          sat[j] <= sk[16];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (en[21+j]) begin
          sat[j] <= sat[j-1];
        end
      end
    end
  end

  // Stage 6 onward: combine luma, clamp, delay to the output stage
  logic [F+8:0] lum_full;
  logic [15:0]  lum [0:NL];
  assign lum_full = ((F + 9)'(qa5) << (F - 3)) + (F + 9)'(q2_5);

  for (genvar j = 0; j <= NL; j++) begin : g_lum
    if (j == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (en[6+j]) begin
          lum[j] <= (lum_full > (F + 9)'(16'hFFFF)) ? 16'hFFFF : 16'(lum_full);
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (en[6+j]) begin
          lum[j] <= lum[j-1];
        end
      end
    end
  end

  // Stage D-1: fold the first-quadrant angle into a full turn
  logic signed [ZW:0] t0, t1, t2, phi_c;
  logic [AW:0]        phi;

  always_comb begin
    if (cf[NI].gray || cz[NI][ZW-1]) begin
      t0 = '0;
    end else if (cz[NI] > QUARTER) begin
      t0 = (ZW + 1)'(QUARTER);
    end else begin
      t0 = (ZW + 1)'(cz[NI]);
    end
    t1    = cf[NI].b_neg ? (ZW + 1)'(HALF) - t0 : t0;
    t2    = cf[NI].a_neg ? -t1 : t1;
    phi_c = t2 + (ZW + 1)'(HALF);
  end

  always_ff @(posedge clk) begin
    if (en[D-1]) begin
      phi <= phi_c[AW:0];
    end
  end

  // Stage D: scale by 255, round to nearest, clamp
  logic [AW+8:0] hue_prod;
  logic [AW+8:0] hue_rnd;
  logic [F+8:0]  hue_full;
  logic [15:0]   hue_r;

  assign hue_prod = ((AW + 9)'(phi) << 8) - (AW + 9)'(phi);
  assign hue_rnd  = hue_prod + (AW + 9)'(longint'(1) <<< (AW - F - 1));
  assign hue_full = hue_rnd[AW+8 -: F+9];

  always_ff @(posedge clk) begin
    if (en[D]) begin
      hue_r <= (hue_full > (F + 9)'(16'hFFFF)) ? 16'hFFFF : 16'(hue_full);
    end
  end

  assign luma       = lum[NL];
  assign hue        = hue_r;
  assign saturation = sat[NS];

endmodule

// ===== design/rlhs_checker.sv =====
// ----------------------------------------------------------------------------
// rlhs_checker: port-level checks for the luma/hue/saturation converter
// Watches the handshakes and output ranges; attached to the top by bind.
// ----------------------------------------------------------------------------
module rlhs_checker #(
  parameter int FRAC_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        pixel_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] luma,
  input logic [15:0] hue,
  input logic [15:0] saturation
);

  localparam longint FULL  = longint'(255) <<< FRAC_BITS;
  localparam longint LIM   = (FULL > 65535) ? 65535 : FULL;
  localparam logic [15:0] LIM16 = 16'(LIM);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(luma)
      && $stable(hue) && $stable(saturation))
    else $error("stalled result changed");

  // Drop all items on reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // An empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("input stalled with empty output");

  // Luma and hue stay within a full scale of 255
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (luma <= LIM16) && (hue <= LIM16))
    else $error("luma or hue out of range");

endmodule

bind rgb_to_luma_hue_saturation rlhs_checker #(.FRAC_BITS(FRAC_BITS)) u_rlhs_checker (.*);
